[rtl/leveled_bucket_store_with_trim_macros.svh]
// Assertion macros for the leveled bucket store.
// Included by the checker module; depends on nothing else.
`ifndef LEVELED_BUCKET_STORE_WITH_TRIM_MACROS_SVH
`define LEVELED_BUCKET_STORE_WITH_TRIM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lbst assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lbst assertion failed");

`endif

[rtl/lbst_pkg.sv]
// Shared types and constants for the leveled bucket store.
// No dependencies; used by the top level.
package lbst_pkg;

  // Fixed field widths of the request and configuration ports.
  localparam int CAP_W = 11;
  localparam int LVL_W = 4;
  localparam int REQ_W = 2;

  typedef logic [CAP_W-1:0] cap_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [REQ_W-1:0] req_t;

  // Request codes.
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_EOC    = 2'd1;
  localparam req_t REQ_QUERY  = 2'd2;

  // Capacity after reset.
  localparam cap_t CAP_RESET = 11'd1024;

endpackage

[rtl/lbst_ram.sv]
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies; instantiated by the bucket store top level.
module lbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/leveled_bucket_store_with_trim.sv]
// Leveled bucket store with end-of-cycle trim: top level.
// Depends on lbst_pkg and lbst_ram.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   in_req_type selects insert (append in_entry_data to bucket in_level),
//   end of cycle (trim to capacity, then snapshot all counts) or query
//   (report the snapshotted count of in_level).
//   Each request yields one result, shown for one cycle with out_strobe high.
//   The receiver has no way to stall; results must be taken as they appear.
//   cfg_we/cfg_wdata write the capacity register; write it only while idle.
// Timing:
//   Insert and query pass through the EXEC, RD0 and FIN states from accept
//   to result strobe; end of cycle passes through WALK, RD0 and FIN, its
//   length set by the walk over the level count memory, which reads one
//   level per cycle and writes back its trimmed count and snapshot. The next
//   request can be accepted in the cycle in which the previous result is strobed.
// Reset:
//   rst_n (synchronous, active low) empties every level and snapshot via
//   per-level valid bits, clears the held count and sets capacity to 1024.
//   The entry memory is not cleared; slot 0 of level 0 is shown only when
//   level 0 holds an entry.
module leveled_bucket_store_with_trim #(
  parameter int NUM_LEVELS      = 16,
  parameter int SLOTS_PER_LEVEL = 64,
  parameter int ENTRY_WIDTH     = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Request channel.
  input  logic                                     start,
  output logic                                     busy,
  input  lbst_pkg::req_t                           in_req_type,
  input  lbst_pkg::lvl_t                           in_level,
  input  logic [ENTRY_WIDTH-1:0]                   in_entry_data,
  // Result channel.
  output logic                                     out_strobe,
  output lbst_pkg::cap_t                           out_total_count,
  output logic [$clog2(SLOTS_PER_LEVEL + 1)-1:0]   out_level_size,
  output logic [ENTRY_WIDTH-1:0]                   out_first_entry,
  output logic                                     out_first_valid,
  output logic                                     out_dropped,
  // Configuration port.
  input  logic                                     cfg_we,
  input  lbst_pkg::cap_t                           cfg_wdata
);

  localparam int LVL_IW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CNT_W     = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int HELD_W    = $clog2(NUM_LEVELS * SLOTS_PER_LEVEL + 1);
  localparam int CMP_W     = (HELD_W > lbst_pkg::CAP_W) ? HELD_W : lbst_pkg::CAP_W;
  localparam int ENT_DEPTH = NUM_LEVELS * SLOTS_PER_LEVEL;
  localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

  // Controller states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_RD0  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  lbst_pkg::cap_t         cap_r;
  logic [HELD_W-1:0]      held_r, held_nxt;
  logic [NUM_LEVELS-1:0]  cnt_vld_r, snap_vld_r;
  logic                   cnt_rvld_r, snap_rvld_r;

  // Latched request.
  lbst_pkg::req_t         req_r;
  logic [LVL_IW-1:0]      lvl_r;
  logic                   lvl_ok_r;
  logic [ENTRY_WIDTH-1:0] data_r;

  // Walk state.
  logic [LVL_IW-1:0]      idx_r;
  logic [CMP_W-1:0]       sum_r, sum_nxt;
  logic                   cut_r, cut_nxt;
  logic                   trim_en_r;

  // Result registers.
  logic                   strobe_r;
  lbst_pkg::cap_t         total_r;
  logic [CNT_W-1:0]       size_r;
  logic [ENTRY_WIDTH-1:0] first_r;
  logic                   first_vld_r;
  logic                   drop_r;

  // Memory ports.
  logic                   cnt_we;
  logic [LVL_IW-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]       cnt_wdata, cnt_q;
  logic                   snap_we;
  logic [CNT_W-1:0]       snap_q;
  logic                   ent_we;
  logic [ENT_AW-1:0]      ent_waddr;
  logic [ENTRY_WIDTH-1:0] ent_q;

  // Datapath values.
  logic [LVL_IW-1:0]      in_lvl_addr;
  logic                   accept;
  logic [CNT_W-1:0]       cnt_cur;
  logic                   ins_ok;
  logic                   over;
  logic [CNT_W-1:0]       walk_cnt;
  logic                   walk_last;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign in_lvl_addr = LVL_IW'(in_level);

  // Count read back from memory; a level never written since reset is empty.
  assign cnt_cur   = cnt_rvld_r ? cnt_q : '0;
  assign ins_ok    = lvl_ok_r && (cnt_cur < CNT_W'(SLOTS_PER_LEVEL));
  assign walk_last = (idx_r == LVL_IW'(NUM_LEVELS - 1));

  // Trim walk: accumulate counts, cut at the level that crosses capacity,
  // empty every level after it; done only if the held count was at least capacity.
  always_comb begin
    sum_nxt  = sum_r + CMP_W'(cnt_cur);
    over     = (sum_nxt > CMP_W'(cap_r));
    cut_nxt  = cut_r;
    walk_cnt = cnt_cur;
    if (trim_en_r) begin
      if (cut_r) begin
        walk_cnt = '0;
      end else if (over) begin
        walk_cnt = CNT_W'(CMP_W'(cap_r) - sum_r);
        cut_nxt  = 1'b1;
      end
    end
  end

  // Memory port steering.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = walk_cnt;
    cnt_raddr = '0;
    snap_we   = 1'b0;
    ent_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cnt_raddr = (in_req_type == lbst_pkg::REQ_EOC) ? '0 : in_lvl_addr;
      end
      ST_EXEC: begin
        cnt_we    = (req_r == lbst_pkg::REQ_INSERT) && ins_ok;
        cnt_waddr = lvl_r;
        cnt_wdata = cnt_cur + CNT_W'(1);
        ent_we    = (req_r == lbst_pkg::REQ_INSERT) && ins_ok;
      end
      ST_WALK: begin
        cnt_we    = 1'b1;
        snap_we   = 1'b1;
        cnt_raddr = LVL_IW'(idx_r + LVL_IW'(1));
      end
      ST_RD0, ST_FIN: begin
        cnt_raddr = '0;
      end
      default: begin
        cnt_raddr = '0;
      end
    endcase
  end

  assign ent_waddr = ENT_AW'(32'(lvl_r) * SLOTS_PER_LEVEL + 32'(cnt_cur));

  // Next state and held count.
  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_req_type == lbst_pkg::REQ_EOC) ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((req_r == lbst_pkg::REQ_INSERT) && ins_ok) begin
          held_nxt = held_r + HELD_W'(1);
        end
        state_nxt = ST_RD0;
      end
      ST_WALK: begin
        if (walk_last) begin
          // A cut leaves exactly capacity entries across all levels.
          if (cut_nxt) begin
            held_nxt = HELD_W'(cap_r);
          end
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_r     <= '0;
      cap_r      <= lbst_pkg::CAP_RESET;
      cnt_vld_r  <= '0;
      snap_vld_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      strobe_r <= (state_r == ST_FIN);
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      if (snap_we) begin
        snap_vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Valid bits that travel with the registered memory reads.
  always_ff @(posedge clk) begin
    cnt_rvld_r  <= cnt_vld_r[cnt_raddr];
    snap_rvld_r <= snap_vld_r[in_lvl_addr];
  end

  // Request latch, walk bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req_type;
      lvl_r     <= in_lvl_addr;
      lvl_ok_r  <= (32'(in_level) < NUM_LEVELS);
      data_r    <= in_entry_data;
      idx_r     <= '0;
      sum_r     <= '0;
      cut_r     <= 1'b0;
      trim_en_r <= (CMP_W'(held_r) >= CMP_W'(cap_r));
      size_r    <= '0;
      drop_r    <= 1'b0;
    end
    if (state_r == ST_EXEC) begin
      case (req_r)
        lbst_pkg::REQ_INSERT: drop_r <= !ins_ok;
        lbst_pkg::REQ_QUERY:  size_r <= (lvl_ok_r && snap_rvld_r) ? snap_q : '0;
        default:              size_r <= '0;
      endcase
    end
    if (state_r == ST_WALK) begin
      idx_r <= LVL_IW'(idx_r + LVL_IW'(1));
      sum_r <= sum_nxt;
      cut_r <= cut_nxt;
    end
    if (state_r == ST_FIN) begin
      total_r     <= lbst_pkg::CAP_W'(held_r);
      first_vld_r <= (cnt_cur != '0);
      first_r     <= (cnt_cur != '0) ? ent_q : '0;
    end
  end

  // Level count memory.
  lbst_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_LEVELS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  // Snapshot memory, read by queries and written by the trim walk.
  lbst_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_LEVELS)
  ) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (idx_r),
    .wdata (walk_cnt),
    .raddr (in_lvl_addr),
    .rdata (snap_q)
  );

  // Entry payload memory; slot 0 of level 0 is read for every result.
  lbst_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (data_r),
    .raddr ('0),
    .rdata (ent_q)
  );

  assign out_strobe      = strobe_r;
  assign out_total_count = total_r;
  assign out_level_size  = size_r;
  assign out_first_entry = first_r;
  assign out_first_valid = first_vld_r;
  assign out_dropped     = drop_r;

endmodule

[rtl/lbst_chk.sv]
// Port-level checker for the leveled bucket store, with its bind statement.
// Depends on leveled_bucket_store_with_trim_macros.svh.
`include "leveled_bucket_store_with_trim_macros.svh"

module lbst_chk #(
  parameter int ENTRY_WIDTH = 32,
  parameter int CNT_W       = 7
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_strobe,
  input logic [CNT_W-1:0]       out_level_size,
  input logic [ENTRY_WIDTH-1:0] out_first_entry,
  input logic                   out_first_valid,
  input logic                   out_dropped
);

  // A result only follows a cycle in which the block was working.
  `LBST_ASSERT_IMP(a_strobe_after_busy, clk, rst_n, out_strobe, $past(busy))

  // An accepted transaction always makes the block busy.
  `LBST_ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)

  // A dropped insert never reports a level size.
  `LBST_ASSERT_IMP(a_drop_no_size, clk, rst_n, out_strobe && out_dropped, out_level_size == '0)

  // An empty level 0 shows a zero first entry.
  `LBST_ASSERT_IMP(a_empty_first, clk, rst_n, out_strobe && !out_first_valid, out_first_entry == '0)

endmodule

bind leveled_bucket_store_with_trim lbst_chk #(
  .ENTRY_WIDTH (ENTRY_WIDTH),
  .CNT_W       ($clog2(SLOTS_PER_LEVEL + 1))
) u_lbst_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_level_size  (out_level_size),
  .out_first_entry (out_first_entry),
  .out_first_valid (out_first_valid),
  .out_dropped     (out_dropped)
);
